[rtl/pfbc_pkg.sv]
`default_nettype none
package pfbc_pkg;

  localparam int FLOW_BITS  = 5;
  localparam int BYTE_BITS  = 31;
  localparam int OUT_BITS   = 53;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS  = 1;
  localparam int QCNT_BITS  = 2;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_DUMP = 1'b1;

  localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

  typedef struct packed {
    logic                 req_type;
    logic [FLOW_BITS-1:0] flow_id;
    logic [BYTE_BITS-1:0] byte_count;
  } in_t;

  typedef struct packed {
    logic [FLOW_BITS-1:0] flow_index;
    logic [OUT_BITS-1:0]  count_value;
    logic                 last;
  } out_t;

  // flow carries the update target, or the walk limit for a dump
  typedef struct packed {
    logic                 is_dump;
    logic [FLOW_BITS-1:0] flow;
    logic [BYTE_BITS-1:0] bytes;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/pfbc_front.sv]
`default_nettype none
module pfbc_front
  import pfbc_pkg::*;
#(
  parameter int NUM_FLOWS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  input  wire logic q_full,
  output logic      q_push,
  output cmd_t      q_cmd
);

  logic [FLOW_BITS-1:0] highest_flow;
  logic                 in_range;
  logic                 accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign in_range = 32'(in_data.flow_id) < NUM_FLOWS;

  // out-of-range updates are dropped here
  assign q_push = accept && ((in_data.req_type == REQ_DUMP) || in_range);

  always_comb begin
    q_cmd.is_dump = (in_data.req_type == REQ_DUMP);
    q_cmd.bytes   = in_data.byte_count;
    q_cmd.flow    = (in_data.req_type == REQ_DUMP) ? highest_flow : in_data.flow_id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      highest_flow <= '0;
    end else if (accept && in_data.req_type == REQ_ADD && in_range &&
                 in_data.flow_id > highest_flow) begin
      highest_flow <= in_data.flow_id;
    end
  end

endmodule
`default_nettype wire

[rtl/pfbc_queue.sv]
`default_nettype none
module pfbc_queue
  import pfbc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head_cmd,
  input  wire logic pop
);

  cmd_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full       = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/pfbc_back.sv]
`default_nettype none
module pfbc_back
  import pfbc_pkg::*;
#(
  parameter int NUM_FLOWS    = 32,
  parameter int COUNTER_BITS = 48
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int AW  = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  localparam int EXT = (COUNTER_BITS > OUT_BITS) ? COUNTER_BITS : OUT_BITS;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DUMP_RD,
    ST_DUMP_OUT,
    ST_DUMP_TOT
  } state_t;

  state_t state;

  logic [COUNTER_BITS-1:0] mem [NUM_FLOWS];
  logic [NUM_FLOWS-1:0]    vld;
  logic [COUNTER_BITS-1:0] rd_data;
  logic                    rd_vld;
  logic [AW-1:0]           rd_addr;

  logic                    s1_valid;
  logic [AW-1:0]           s1_addr;
  logic [BYTE_BITS-1:0]    s1_bytes;
  logic                    fwd_valid;
  logic [AW-1:0]           fwd_addr;
  logic [COUNTER_BITS-1:0] fwd_data;

  logic [FLOW_BITS-1:0]    walk;
  logic [FLOW_BITS-1:0]    limit;
  logic [OUT_BITS-1:0]     total;

  logic [COUNTER_BITS-1:0] base;
  logic [COUNTER_BITS:0]   sum;
  logic [COUNTER_BITS-1:0] upd;
  logic [COUNTER_BITS-1:0] cur;
  logic [EXT-1:0]          cur_ext;
  logic [OUT_BITS-1:0]     cur_out;
  logic [OUT_BITS:0]       tot_sum;
  logic [OUT_BITS-1:0]     tot_next;
  logic                    out_free;
  logic                    clear_en;

  assign cmd_pop  = (state == ST_RUN) && cmd_valid;
  assign out_free = !out_valid || !out_stall;
  assign rd_addr  = (state == ST_RUN) ? AW'(cmd.flow) : AW'(walk);
  assign clear_en = (state == ST_DUMP_OUT) && out_free;

  // update path with bypass of the write made as this read was taken
  always_comb begin
    if (fwd_valid && fwd_addr == s1_addr) begin
      base = fwd_data;
    end else if (rd_vld) begin
      base = rd_data;
    end else begin
      base = '0;
    end
    sum = {1'b0, base} + (COUNTER_BITS + 1)'(s1_bytes);
    upd = sum[COUNTER_BITS] ? CNT_MAX : sum[COUNTER_BITS-1:0];
  end

  // dump path
  always_comb begin
    cur      = rd_vld ? rd_data : '0;
    cur_ext  = EXT'(cur);
    cur_out  = (cur_ext > EXT'(OUT_MAX)) ? OUT_MAX : cur_ext[OUT_BITS-1:0];
    tot_sum  = {1'b0, total} + {1'b0, cur_out};
    tot_next = tot_sum[OUT_BITS] ? OUT_MAX : tot_sum[OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (s1_valid) begin
      mem[s1_addr] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[rd_addr];
      if (s1_valid) begin
        vld[s1_addr] <= 1'b1;
      end
      if (clear_en) begin
        vld[AW'(walk)] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= cmd_pop && !cmd.is_dump;
      s1_addr   <= AW'(cmd.flow);
      s1_bytes  <= cmd.bytes;
      fwd_valid <= s1_valid;
      fwd_addr  <= s1_addr;
      fwd_data  <= upd;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_RUN: begin
          if (cmd_pop && cmd.is_dump) begin
            walk  <= '0;
            limit <= cmd.flow;
            total <= '0;
            state <= ST_DUMP_RD;
          end
        end
        ST_DUMP_RD: begin
          state <= ST_DUMP_OUT;
        end
        ST_DUMP_OUT: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_data.flow_index  <= walk;
            out_data.count_value <= cur_out;
            out_data.last        <= 1'b0;
            total                <= tot_next;
            if (walk == limit) begin
              state <= ST_DUMP_TOT;
            end else begin
              walk  <= walk + 1'b1;
              state <= ST_DUMP_RD;
            end
          end
        end
        ST_DUMP_TOT: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_data.flow_index  <= '0;
            out_data.count_value <= total;
            out_data.last        <= 1'b1;
            state                <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/per_flow_byte_counters_core.sv]
// update: one transfer per cycle while no dump holds the back end, applied through
// the queue (counter read, then saturating add and write back), no result
// dump: per flow walked a counter read, then a result out that waits while the
// output is stalled, then one result for the total
// reset: synchronous, clears all counters and the highest flow at once, no sweep
`default_nettype none
module per_flow_byte_counters_core
  import pfbc_pkg::*;
#(
  parameter int NUM_FLOWS    = 32,
  parameter int COUNTER_BITS = 48
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic q_push;
  cmd_t q_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_head;
  logic q_pop;

  pfbc_front #(
    .NUM_FLOWS(NUM_FLOWS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  pfbc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .head_valid(q_valid),
    .head_cmd  (q_head),
    .pop       (q_pop)
  );

  pfbc_back #(
    .NUM_FLOWS   (NUM_FLOWS),
    .COUNTER_BITS(COUNTER_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(q_valid),
    .cmd      (q_head),
    .cmd_pop  (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue read while empty");

  a_total_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> out_data.flow_index == '0)
    else $error("total transfer carries a flow index");
`endif

endmodule
`default_nettype wire

[tb/flow_count_checker.sv]
module flow_count_checker
  import pfbc_pkg::*;
#(
  parameter int NUM_FLOWS    = 32,
  parameter int COUNTER_BITS = 48
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_stall,
  input  wire in_t  in_data,
  input  wire logic out_valid,
  input  wire logic out_stall,
  input  wire out_t out_data,
  output int        reports_waiting,
  output int        fault_total
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [COUNTER_BITS-1:0] flow_bytes [NUM_FLOWS];
  logic [FLOW_BITS-1:0]    top_flow;
  out_t                    expected_reports [$];
  int                      faults;

  task automatic account(input in_t req);
    logic [COUNTER_BITS:0] sum;
    logic [OUT_BITS:0]     total;
    logic [OUT_BITS-1:0]   shown;
    out_t                  rpt;
    int                    j;
    if (req.req_type == REQ_ADD) begin
      if (req.flow_id < NUM_FLOWS) begin
        if (req.flow_id > top_flow) top_flow = req.flow_id;
        sum = flow_bytes[req.flow_id] + req.byte_count;
        flow_bytes[req.flow_id] = sum[COUNTER_BITS] ? '1 : sum[COUNTER_BITS-1:0];
      end
    end else begin
      total = '0;
      for (j = 0; j <= top_flow && j < NUM_FLOWS; j++) begin
        shown = (flow_bytes[j] > OUT_MAX) ? OUT_MAX : OUT_BITS'(flow_bytes[j]);
        rpt.flow_index = FLOW_BITS'(j);
        rpt.count_value = shown;
        rpt.last = 1'b0;
        expected_reports.push_back(rpt);
        total = total + shown;
        if (total > OUT_MAX) total = OUT_MAX;
        flow_bytes[j] = '0;
      end
      rpt.flow_index = '0;
      rpt.count_value = total[OUT_BITS-1:0];
      rpt.last = 1'b1;
      expected_reports.push_back(rpt);
    end
  endtask

  task automatic compare_report(input out_t got);
    out_t want;
    if (expected_reports.size() == 0) begin
      $error("unexpected transfer: flow_index %0d count_value %0d last %0d",
             got.flow_index, got.count_value, got.last);
      faults++;
    end else begin
      want = expected_reports.pop_front();
      if (got.flow_index !== want.flow_index) begin
        $error("flow_index: expected %0d, got %0d", want.flow_index, got.flow_index);
        faults++;
      end
      if (got.count_value !== want.count_value) begin
        $error("count_value: expected %0d, got %0d", want.count_value, got.count_value);
        faults++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        faults++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_FLOWS; k++) flow_bytes[k] = '0;
      top_flow = '0;
      expected_reports.delete();
    end else begin
      if (in_valid && !in_stall) account(in_data);
      if (out_valid && !out_stall) compare_report(out_data);
    end
    reports_waiting <= expected_reports.size();
    fault_total <= faults;
  end

endmodule

[tb/per_flow_byte_counters_core_tb.sv]
module per_flow_byte_counters_core_tb
  import pfbc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FLOWS    = 32;
  localparam int COUNTER_BITS = 48;
  localparam int RANDOM_ITEMS = 460;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 24;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam logic [BYTE_BITS-1:0] MAX_BYTES = '1;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  int   reports_waiting;
  int   fault_total;
  int   hold_requests = 0;
  int   cycle_count = 0;
  logic src_calm = 1'b0;

  per_flow_byte_counters_core #(
    .NUM_FLOWS(NUM_FLOWS),
    .COUNTER_BITS(COUNTER_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  flow_count_checker #(
    .NUM_FLOWS(NUM_FLOWS),
    .COUNTER_BITS(COUNTER_BITS)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .reports_waiting(reports_waiting),
    .fault_total(fault_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_t update_req(input logic [FLOW_BITS-1:0] flow,
                                     input logic [BYTE_BITS-1:0] bytes);
    in_t r;
    r.req_type = REQ_ADD;
    r.flow_id = flow;
    r.byte_count = bytes;
    return r;
  endfunction

  function automatic in_t dump_req();
    in_t r;
    r.req_type = REQ_DUMP;
    r.flow_id = FLOW_BITS'($urandom);
    r.byte_count = BYTE_BITS'($urandom);
    return r;
  endfunction

  function automatic in_t random_update(input int bound);
    logic [BYTE_BITS-1:0] bytes;
    case ($urandom_range(0, 3))
      0: bytes = BYTE_BITS'($urandom_range(0, 255));
      1: bytes = MAX_BYTES - BYTE_BITS'($urandom_range(0, 15));
      default: bytes = BYTE_BITS'($urandom);
    endcase
    return update_req(FLOW_BITS'($urandom_range(0, bound)), bytes);
  endfunction

  task automatic send(input in_t item);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_waiting != 0);
  endtask

  initial begin : sink
    int   pause;
    int   holds_served;
    logic calm;
    out_stall = 1'b0;
    holds_served = 0;
    calm = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_requests != holds_served) begin
        pause = HOLD_CYCLES;
        holds_served = hold_requests;
      end else begin
        pause = calm ? 0 : $urandom_range(0, 19);
      end
      if ($urandom_range(0, 47) == 0) calm = !calm;
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && hold_requests == holds_served);
    end
  end

  initial begin
    int i;
    int bound;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store, extremes, consecutive updates to one flow, dump as the next request after an update
    send(dump_req());
    send(update_req(5'd0, '0));
    send(update_req(5'd0, MAX_BYTES));
    send(update_req(5'd0, MAX_BYTES));
    send(update_req(5'd2, 31'h5555_5555));
    send(update_req(5'd1, 31'h2AAA_AAAA));
    send(dump_req());
    send(dump_req());
    send(update_req(5'd2, 31'd1));
    send(dump_req());
    send(update_req(5'd1, MAX_BYTES));
    send(update_req(5'd1, MAX_BYTES));
    send(update_req(5'd1, MAX_BYTES));
    send(dump_req());
    drain_reports();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      bound = (i * NUM_FLOWS) / 380;
      if (bound > NUM_FLOWS - 1) bound = NUM_FLOWS - 1;
      if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
      if (i == 180) begin
        // long output hold-off while transfers keep coming
        drain_reports();
        hold_requests <= hold_requests + 1;
        send(dump_req());
        repeat (12) send(random_update(bound));
      end
      if (i == 320) drain_reports();
      if ($urandom_range(0, 11) == 0) send(dump_req());
      else send(random_update(bound));
    end
    send(dump_req());
    drain_reports();

    // back-to-back updates to one flow, then the top flow
    src_calm = 1'b1;
    send(update_req(5'd7, MAX_BYTES));
    send(update_req(5'd7, 31'd3));
    send(dump_req());
    src_calm = 1'b0;
    send(update_req(5'd31, MAX_BYTES));
    send(dump_req());

    drain_reports();
    repeat (SETTLE) @(posedge clk);
    if (fault_total == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
rtl/pfbc_pkg.sv
rtl/pfbc_front.sv
rtl/pfbc_queue.sv
rtl/pfbc_back.sv
rtl/per_flow_byte_counters_core.sv
tb/flow_count_checker.sv
tb/per_flow_byte_counters_core_tb.sv
